>>> hw/rtl/bra_pkg.sv
// Shared types and constants of the best rational approximation unit.
package bra_pkg;

  // Fixed field widths of the configuration and result ports
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned WHOLE_W = 17;
  localparam int unsigned NUM_W   = 18;
  localparam int unsigned DEN_W   = 17;

  // Reset value of the maximum denominator register
  localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_GCD,
    ST_DIV,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture a new beat value and reset the search
    logic issue;     // push the next denominator into the search pipeline
    logic gcd_init;  // start the gcd on the best numerator and denominator
    logic gcd_step;  // one binary gcd step
    logic div_init;  // start dividing by the gcd
    logic div_step;  // one quotient bit on both lanes
    logic out_load;  // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic frac_zero;  // fraction of the captured value is zero
    logic last_d;     // denominator about to issue is the last one
    logic pipe_busy;  // search pipeline still holds candidates
    logic num_zero;   // best numerator is zero
    logic gcd_done;   // gcd operands have met
    logic div_done;   // all quotient bits produced
  } status_t;

endpackage

>>> hw/rtl/best_rational_approximation_unit.sv
// Top level of the best rational approximation unit.
// Splits a signed fixed-point beat value into its whole part, truncated toward
// zero, and the fraction as a reduced numerator over denominator, the sign on
// the numerator. One item is worked at a time. When the fraction is zero the
// search is skipped, and when the best numerator is zero the gcd and the
// division are skipped. The search pipeline tries one denominator a cycle from
// 1 up to the effective maximum (a written 0 counts as 1, values above
// DEN_LIMIT count as DEN_LIMIT) and then drains; the binary gcd (at most 2*DW
// steps, with DW = clog2(DEN_LIMIT+1)) and the shift-subtract divider (DW
// steps) follow. The result sits in an output register, and the next item is
// taken the cycle after that result is loaded; a stalled output holds the
// finished item back until its register is free. The user must write
// max_denominator through the configuration channel only while the unit is
// idle; the unit itself does not enforce this.
module best_rational_approximation_unit #(
  parameter int unsigned FRAC_BITS = 32,
  parameter int unsigned INT_BITS  = 17,
  parameter int unsigned DEN_LIMIT = 65536
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic signed [INT_BITS+FRAC_BITS-1:0]       beat_value_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic signed [bra_pkg::WHOLE_W-1:0]         beat_whole_o,
  output logic signed [bra_pkg::NUM_W-1:0]           frac_numerator_o,
  output logic [bra_pkg::DEN_W-1:0]                  frac_denominator_o,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [bra_pkg::CFG_W-1:0]                  cfg_data_i
);

  localparam int unsigned DW = $clog2(DEN_LIMIT + 1);

  logic [bra_pkg::CFG_W-1:0] max_den_q;
  logic [DW-1:0]             max_den_eff;
  bra_pkg::cmd_t             cmd;
  bra_pkg::status_t          status;

  // Configuration register, written on every transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_den_q <= bra_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_den_q <= cfg_data_i;
    end
  end

  // Clamp the search limit to 1..DEN_LIMIT
  always_comb begin
    if (max_den_q == '0) begin
      max_den_eff = DW'(1);
    end else if (32'(max_den_q) > 32'(DEN_LIMIT)) begin
      max_den_eff = DW'(DEN_LIMIT);
    end else begin
      max_den_eff = DW'(max_den_q);
    end
  end

  bra_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bra_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS),
    .DEN_LIMIT (DEN_LIMIT)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .beat_value_i       (beat_value_i),
    .max_den_i          (max_den_eff),
    .beat_whole_o       (beat_whole_o),
    .frac_numerator_o   (frac_numerator_o),
    .frac_denominator_o (frac_denominator_o)
  );

endmodule

>>> hw/rtl/bra_controller.sv
// Controller state machine of the best rational approximation unit.
module bra_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  bra_pkg::status_t  status_i,
  output bra_pkg::cmd_t     cmd_o
);

  bra_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bra_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != bra_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequence search, drain, gcd, divide and result transfer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      bra_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bra_pkg::ST_SEARCH;
        end
      end
      bra_pkg::ST_SEARCH: begin
        if (status_i.frac_zero) begin
          state_d = bra_pkg::ST_FINISH;
        end else begin
          cmd_o.issue = 1'b1;
          if (status_i.last_d) begin
            state_d = bra_pkg::ST_DRAIN;
          end
        end
      end
      bra_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          if (status_i.num_zero) begin
            state_d = bra_pkg::ST_FINISH;
          end else begin
            cmd_o.gcd_init = 1'b1;
            state_d        = bra_pkg::ST_GCD;
          end
        end
      end
      bra_pkg::ST_GCD: begin
        if (status_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = bra_pkg::ST_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      bra_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          state_d = bra_pkg::ST_FINISH;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      bra_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = bra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bra_pkg::ST_IDLE;
      end
    endcase
  end

  // Drop valid after a transfer, raise it on a new result
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an untaken result");

  a_accept_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == bra_pkg::ST_SEARCH))
    else $error("accepted item did not start the search");

  a_drain_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bra_pkg::ST_DRAIN && !status_i.pipe_busy)
      |=> (state_q != bra_pkg::ST_DRAIN))
    else $error("drain did not end on an empty pipeline");
`endif

endmodule

>>> hw/rtl/bra_datapath.sv
// Datapath of the best rational approximation unit: search pipeline, gcd and divider.
module bra_datapath #(
  parameter int unsigned FRAC_BITS = 32,
  parameter int unsigned INT_BITS  = 17,
  parameter int unsigned DEN_LIMIT = 65536,
  localparam int unsigned IW = INT_BITS + FRAC_BITS,
  localparam int unsigned DW = $clog2(DEN_LIMIT + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bra_pkg::cmd_t                      cmd_i,
  output bra_pkg::status_t                   status_o,
  input  logic [IW-1:0]                      beat_value_i,
  input  logic [DW-1:0]                      max_den_i,
  output logic signed [bra_pkg::WHOLE_W-1:0] beat_whole_o,
  output logic signed [bra_pkg::NUM_W-1:0]   frac_numerator_o,
  output logic [bra_pkg::DEN_W-1:0]          frac_denominator_o
);

  localparam int unsigned PW  = FRAC_BITS + DW;
  localparam int unsigned LW  = FRAC_BITS + 1 + DW;
  localparam int unsigned KW  = $clog2(DW + 1);
  localparam int unsigned XW  = INT_BITS + bra_pkg::WHOLE_W;
  localparam int unsigned NXW = DW + bra_pkg::NUM_W;
  localparam int unsigned DXW = DW + bra_pkg::DEN_W;

  // One quotient bit of a restoring division; returns {remainder, shifted dividend}
  function automatic logic [2*DW-1:0] div_bit(input logic [DW-1:0] r,
                                              input logic [DW-1:0] s,
                                              input logic [DW-1:0] g);
    logic [DW:0] t;
    logic [DW:0] u;
    logic        q;
    t = {r, s[DW-1]};
    q = (t >= {1'b0, g});
    u = q ? (t - {1'b0, g}) : t;
    return {u[DW-1:0], s[DW-2:0], q};
  endfunction

  // Input split
  logic                 sign_in;
  logic [IW-1:0]        mag_in;
  logic                 neg_q;
  logic [INT_BITS-1:0]  whole_q;
  logic [FRAC_BITS-1:0] f_q;

  // Search pipeline
  logic [DW-1:0]        d_q;
  logic                 v1_q, v2_q;
  logic [PW-1:0]        p1_q;
  logic [DW-1:0]        d1_q, d2_q, n2_q;
  logic [FRAC_BITS-1:0] e2_q;
  logic [PW-1:0]        prod1;
  logic [PW:0]          rnd;
  logic [DW:0]          n_raw;
  logic [DW-1:0]        n_clamp;
  logic [PW-1:0]        q_full, e_full;
  logic [LW-1:0]        lhs, rhs;
  logic                 better;
  logic [FRAC_BITS:0]   best_e_q;
  logic [DW-1:0]        best_d_q, best_n_q;

  // Reduction
  logic [DW-1:0]        a_q, b_q, g_q;
  logic [KW-1:0]        k_q;
  logic [DW-1:0]        sn_q, sd_q, rn_q, rd_q;
  logic [KW-1:0]        cnt_q;
  logic [2*DW-1:0]      lane_n, lane_d;

  // Result formatting
  logic [XW-1:0]        whole_x, whole_s;
  logic [NXW-1:0]       num_x, num_s;
  logic [DXW-1:0]       den_x;

  assign sign_in = beat_value_i[IW-1];
  assign mag_in  = sign_in ? (~beat_value_i + IW'(1)) : beat_value_i;

  // Capture the split value
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q   <= sign_in;
      whole_q <= mag_in[IW-1:FRAC_BITS];
      f_q     <= mag_in[FRAC_BITS-1:0];
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  // Stage 1: scale the fraction by the candidate denominator
  assign prod1 = PW'(f_q) * PW'(d_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d_q <= DW'(1);
    end else if (cmd_i.issue) begin
      d_q <= d_q + DW'(1);
    end
    if (cmd_i.issue) begin
      p1_q <= prod1;
      d1_q <= d_q;
    end
  end

  // Stage 2: round half up, clamp, take the absolute error
  assign rnd     = {1'b0, p1_q} + ((PW + 1)'(1) << (FRAC_BITS - 1));
  assign n_raw   = rnd[PW:FRAC_BITS];
  assign n_clamp = (n_raw > {1'b0, d1_q}) ? d1_q : n_raw[DW-1:0];
  assign q_full  = {n_clamp, {FRAC_BITS{1'b0}}};
  assign e_full  = (p1_q >= q_full) ? (p1_q - q_full) : (q_full - p1_q);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      e2_q <= e_full[FRAC_BITS-1:0];
      n2_q <= n_clamp;
      d2_q <= d1_q;
    end
  end

  // Stage 3: cross-multiply against the best so far, keep a strictly smaller error
  assign lhs    = LW'(e2_q) * LW'(best_d_q);
  assign rhs    = LW'(best_e_q) * LW'(d2_q);
  assign better = (lhs < rhs);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      best_e_q <= (FRAC_BITS + 1)'(1) << FRAC_BITS;
      best_d_q <= DW'(1);
      best_n_q <= '0;
    end else if (v2_q && better) begin
      best_e_q <= {1'b0, e2_q};
      best_d_q <= d2_q;
      best_n_q <= n2_q;
    end
  end

  // Binary gcd of the best pair, one step a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      a_q <= best_n_q;
      b_q <= best_d_q;
      k_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + KW'(1);
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q > b_q) begin
        a_q <= (a_q - b_q) >> 1;
      end else begin
        b_q <= (b_q - a_q) >> 1;
      end
    end
  end

  // Divide numerator and denominator by the gcd, one quotient bit a cycle
  assign lane_n = div_bit(rn_q, sn_q, g_q);
  assign lane_d = div_bit(rd_q, sd_q, g_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sn_q <= '0;
      sd_q <= DW'(1);
    end else if (cmd_i.div_init) begin
      g_q   <= a_q << k_q;
      sn_q  <= best_n_q;
      sd_q  <= best_d_q;
      rn_q  <= '0;
      rd_q  <= '0;
      cnt_q <= KW'(DW);
    end else if (cmd_i.div_step) begin
      {rn_q, sn_q} <= lane_n;
      {rd_q, sd_q} <= lane_d;
      cnt_q        <= cnt_q - KW'(1);
    end
  end

  // Apply the sign and fit the result fields
  assign whole_x = XW'(whole_q);
  assign whole_s = neg_q ? (~whole_x + XW'(1)) : whole_x;
  assign num_x   = NXW'(sn_q);
  assign num_s   = neg_q ? (~num_x + NXW'(1)) : num_x;
  assign den_x   = DXW'(sd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      beat_whole_o       <= whole_s[bra_pkg::WHOLE_W-1:0];
      frac_numerator_o   <= num_s[bra_pkg::NUM_W-1:0];
      frac_denominator_o <= den_x[bra_pkg::DEN_W-1:0];
    end
  end

  assign status_o.frac_zero = (f_q == '0);
  assign status_o.last_d    = (d_q == max_den_i);
  assign status_o.pipe_busy = v1_q || v2_q;
  assign status_o.num_zero  = (best_n_q == '0);
  assign status_o.gcd_done  = (a_q == b_q);
  assign status_o.div_done  = (cnt_q == '0);

`ifndef SYNTHESIS
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gcd_step |-> (a_q != '0 && b_q != '0))
    else $error("gcd operand reached zero");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (g_q != '0))
    else $error("division by a zero gcd");
`endif

endmodule
